/* rtl/rmd160_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmd160_pkg
// Shared types, round tables and helper functions for the RIPEMD-160
// single-block hash pipeline.
// ----------------------------------------------------------------------------
package rmd160_pkg;

    localparam int NUM_ROUNDS = 80;
    localparam int MSG_WORDS  = 8;

    // one working line: five 32-bit chaining words
    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
        logic [31:0] e;
    } rmd_line_t;

    // everything that travels down the pipeline with one request
    typedef struct packed {
        rmd_line_t                      left;
        rmd_line_t                      right;
        logic [MSG_WORDS-1:0][31:0]     msg;
    } rmd_state_t;

    // initial chaining values
    localparam logic [31:0] H0 = 32'h67452301;
    localparam logic [31:0] H1 = 32'hEFCDAB89;
    localparam logic [31:0] H2 = 32'h98BADCFE;
    localparam logic [31:0] H3 = 32'h10325476;
    localparam logic [31:0] H4 = 32'hC3D2E1F0;

    // padding words of the fixed 32-byte message block
    localparam logic [3:0]  PAD_MARK_IDX  = 4'd8;
    localparam logic [3:0]  PAD_LEN_IDX   = 4'd14;
    localparam logic [31:0] PAD_MARK_WORD = 32'h00000080;
    localparam logic [31:0] PAD_LEN_WORD  = 32'd256;

    localparam logic [4:0]  ROT_C = 5'd10;

    localparam logic [3:0] SEL_LEFT [NUM_ROUNDS] = '{
        4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7,
        4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15,
        4'd7, 4'd4, 4'd13, 4'd1, 4'd10, 4'd6, 4'd15, 4'd3,
        4'd12, 4'd0, 4'd9, 4'd5, 4'd2, 4'd14, 4'd11, 4'd8,
        4'd3, 4'd10, 4'd14, 4'd4, 4'd9, 4'd15, 4'd8, 4'd1,
        4'd2, 4'd7, 4'd0, 4'd6, 4'd13, 4'd11, 4'd5, 4'd12,
        4'd1, 4'd9, 4'd11, 4'd10, 4'd0, 4'd8, 4'd12, 4'd4,
        4'd13, 4'd3, 4'd7, 4'd15, 4'd14, 4'd5, 4'd6, 4'd2,
        4'd4, 4'd0, 4'd5, 4'd9, 4'd7, 4'd12, 4'd2, 4'd10,
        4'd14, 4'd1, 4'd3, 4'd8, 4'd11, 4'd6, 4'd15, 4'd13
    };

    localparam logic [3:0] SEL_RIGHT [NUM_ROUNDS] = '{
        4'd5, 4'd14, 4'd7, 4'd0, 4'd9, 4'd2, 4'd11, 4'd4,
        4'd13, 4'd6, 4'd15, 4'd8, 4'd1, 4'd10, 4'd3, 4'd12,
        4'd6, 4'd11, 4'd3, 4'd7, 4'd0, 4'd13, 4'd5, 4'd10,
        4'd14, 4'd15, 4'd8, 4'd12, 4'd4, 4'd9, 4'd1, 4'd2,
        4'd15, 4'd5, 4'd1, 4'd3, 4'd7, 4'd14, 4'd6, 4'd9,
        4'd11, 4'd8, 4'd12, 4'd2, 4'd10, 4'd0, 4'd4, 4'd13,
        4'd8, 4'd6, 4'd4, 4'd1, 4'd3, 4'd11, 4'd15, 4'd0,
        4'd5, 4'd12, 4'd2, 4'd13, 4'd9, 4'd7, 4'd10, 4'd14,
        4'd12, 4'd15, 4'd10, 4'd4, 4'd1, 4'd5, 4'd8, 4'd7,
        4'd6, 4'd2, 4'd13, 4'd14, 4'd0, 4'd3, 4'd9, 4'd11
    };

    localparam logic [4:0] ROT_LEFT [NUM_ROUNDS] = '{
        5'd11, 5'd14, 5'd15, 5'd12, 5'd5, 5'd8, 5'd7, 5'd9,
        5'd11, 5'd13, 5'd14, 5'd15, 5'd6, 5'd7, 5'd9, 5'd8,
        5'd7, 5'd6, 5'd8, 5'd13, 5'd11, 5'd9, 5'd7, 5'd15,
        5'd7, 5'd12, 5'd15, 5'd9, 5'd11, 5'd7, 5'd13, 5'd12,
        5'd11, 5'd13, 5'd6, 5'd7, 5'd14, 5'd9, 5'd13, 5'd15,
        5'd14, 5'd8, 5'd13, 5'd6, 5'd5, 5'd12, 5'd7, 5'd5,
        5'd11, 5'd12, 5'd14, 5'd15, 5'd14, 5'd15, 5'd9, 5'd8,
        5'd9, 5'd14, 5'd5, 5'd6, 5'd8, 5'd6, 5'd5, 5'd12,
        5'd9, 5'd15, 5'd5, 5'd11, 5'd6, 5'd8, 5'd13, 5'd12,
        5'd5, 5'd12, 5'd13, 5'd14, 5'd11, 5'd8, 5'd5, 5'd6
    };

    localparam logic [4:0] ROT_RIGHT [NUM_ROUNDS] = '{
        5'd8, 5'd9, 5'd9, 5'd11, 5'd13, 5'd15, 5'd15, 5'd5,
        5'd7, 5'd7, 5'd8, 5'd11, 5'd14, 5'd14, 5'd12, 5'd6,
        5'd9, 5'd13, 5'd15, 5'd7, 5'd12, 5'd8, 5'd9, 5'd11,
        5'd7, 5'd7, 5'd12, 5'd7, 5'd6, 5'd15, 5'd13, 5'd11,
        5'd9, 5'd7, 5'd15, 5'd11, 5'd8, 5'd6, 5'd6, 5'd14,
        5'd12, 5'd13, 5'd5, 5'd14, 5'd13, 5'd13, 5'd7, 5'd5,
        5'd15, 5'd5, 5'd8, 5'd11, 5'd14, 5'd14, 5'd6, 5'd14,
        5'd6, 5'd9, 5'd12, 5'd9, 5'd12, 5'd5, 5'd15, 5'd8,
        5'd8, 5'd5, 5'd12, 5'd9, 5'd12, 5'd5, 5'd14, 5'd6,
        5'd8, 5'd13, 5'd6, 5'd5, 5'd15, 5'd13, 5'd11, 5'd11
    };

    localparam logic [31:0] K_LEFT [5] = '{
        32'h00000000, 32'h5A827999, 32'h6ED9EBA1, 32'h8F1BBCDC, 32'hA953FD4E
    };

    localparam logic [31:0] K_RIGHT [5] = '{
        32'h50A28BE6, 32'h5C4DD124, 32'h6D703EF3, 32'h7A6D76E9, 32'h00000000
    };

    // Boolean function codes
    localparam logic [2:0] FN_XOR  = 3'd0;
    localparam logic [2:0] FN_MUX  = 3'd1;
    localparam logic [2:0] FN_ORN  = 3'd2;
    localparam logic [2:0] FN_MUXZ = 3'd3;
    localparam logic [2:0] FN_XORN = 3'd4;

    // rotate left by n
    function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] n);
        logic [63:0] dbl;
        dbl = {x, x} << n;
        return dbl[63:32];
    endfunction

    // the five round functions
    function automatic logic [31:0] bool_fn(input logic [2:0] sel, input logic [31:0] x,
                                            input logic [31:0] y, input logic [31:0] z);
        logic [31:0] r;
        case (sel)
            FN_XOR:  r = x ^ y ^ z;
            FN_MUX:  r = (x & y) | (~x & z);
            FN_ORN:  r = (x | ~y) ^ z;
            FN_MUXZ: r = (x & z) | (y & ~z);
            default: r = x ^ (y | ~z);
        endcase
        return r;
    endfunction

    // word of the padded block: message words, then padding constants
    function automatic logic [31:0] block_word(input logic [MSG_WORDS-1:0][31:0] msg,
                                               input logic [3:0] idx);
        logic [31:0] r;
        if (idx[3] == 1'b0)
            r = msg[idx[2:0]];
        else if (idx == PAD_MARK_IDX)
            r = PAD_MARK_WORD;
        else if (idx == PAD_LEN_IDX)
            r = PAD_LEN_WORD;
        else
            r = 32'd0;
        return r;
    endfunction

endpackage

/* rtl/rmd160_round.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmd160_round
// One pipeline stage: a single round of both the left and the right line,
// with its own valid bit and a bubble-collapsing ready.
// ----------------------------------------------------------------------------
module rmd160_round
    import rmd160_pkg::*;
#(
    parameter int ROUND = 0
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  rmd_state_t in_state,
    output logic       out_valid,
    input  logic       out_ready,
    output rmd_state_t out_state
);

    localparam int         GRP    = ROUND / 16;
    localparam logic [2:0] FN_L   = 3'(GRP);
    localparam logic [2:0] FN_R   = 3'(4 - GRP);
    localparam logic [3:0] SL     = SEL_LEFT[ROUND];
    localparam logic [3:0] SR     = SEL_RIGHT[ROUND];
    localparam logic [4:0] RL     = ROT_LEFT[ROUND];
    localparam logic [4:0] RR     = ROT_RIGHT[ROUND];
    localparam logic [31:0] KL    = K_LEFT[GRP];
    localparam logic [31:0] KR    = K_RIGHT[GRP];

    logic       valid_reg;
    rmd_state_t state_reg;
    rmd_state_t state_next;
    logic [31:0] sum_l;
    logic [31:0] sum_r;

    // round arithmetic for both lines
    always_comb
    begin
        sum_l = in_state.left.a + bool_fn(FN_L, in_state.left.b, in_state.left.c,
                                          in_state.left.d)
                + block_word(in_state.msg, SL) + KL;
        sum_r = in_state.right.a + bool_fn(FN_R, in_state.right.b, in_state.right.c,
                                           in_state.right.d)
                + block_word(in_state.msg, SR) + KR;

        state_next.left.a  = in_state.left.e;
        state_next.left.e  = in_state.left.d;
        state_next.left.d  = rotl32(in_state.left.c, ROT_C);
        state_next.left.c  = in_state.left.b;
        state_next.left.b  = rotl32(sum_l, RL) + in_state.left.e;

        state_next.right.a = in_state.right.e;
        state_next.right.e = in_state.right.d;
        state_next.right.d = rotl32(in_state.right.c, ROT_C);
        state_next.right.c = in_state.right.b;
        state_next.right.b = rotl32(sum_r, RR) + in_state.right.e;

        state_next.msg     = in_state.msg;
    end

    // stage takes a request when empty or when its contents move on
    assign in_ready = !valid_reg || out_ready;

    // valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            state_reg <= state_next;
    end

    assign out_valid = valid_reg;
    assign out_state = state_reg;

endmodule

/* rtl/rmd160_final.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmd160_final
// Cross-addition of the two lines with the initial chaining values, and the
// output register that holds the digest until it is taken.
// ----------------------------------------------------------------------------
module rmd160_final
    import rmd160_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  rmd_state_t  in_state,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] digest_word_0,
    output logic [63:0] digest_word_1,
    output logic [31:0] digest_word_2
);

    logic        valid_reg;
    logic [31:0] h0_next;
    logic [31:0] h1_next;
    logic [31:0] h2_next;
    logic [31:0] h3_next;
    logic [31:0] h4_next;
    logic [63:0] dw0_reg;
    logic [63:0] dw1_reg;
    logic [31:0] dw2_reg;

    // final cross-addition
    always_comb
    begin
        h0_next = H1 + in_state.left.c + in_state.right.d;
        h1_next = H2 + in_state.left.d + in_state.right.e;
        h2_next = H3 + in_state.left.e + in_state.right.a;
        h3_next = H4 + in_state.left.a + in_state.right.b;
        h4_next = H0 + in_state.left.b + in_state.right.c;
    end

    assign in_ready = !valid_reg || out_ready;

    // output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    // digest register
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            dw0_reg <= {h1_next, h0_next};
            dw1_reg <= {h3_next, h2_next};
            dw2_reg <= h4_next;
        end
    end

    assign out_valid     = valid_reg;
    assign digest_word_0 = dw0_reg;
    assign digest_word_1 = dw1_reg;
    assign digest_word_2 = dw2_reg;

endmodule

/* rtl/ripemd160_32byte_hash.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ripemd160_32byte_hash
// RIPEMD-160 digest of one 32-byte message, fully unrolled round pipeline.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_ready) carries one 32-byte message per
//   request as four little-endian 64-bit words. The output channel
//   (out_valid / out_ready) returns the 20-byte digest as two 64-bit words
//   and one 32-bit word, byte 0 in the low bits.
//   The message is padded to one 64-byte block inside the block; there is
//   no state between messages.
//   The pipeline has 80 round stages (one left and one right round each)
//   plus the cross-add and output register. Throughput is one request per
//   cycle unless the receiver stalls, set by the single-round stage depth.
//   Reset clears all valid bits; the pipeline comes up empty and ready.
//   When the receiver stalls, results pile up stage by stage: each stage
//   keeps taking data while it or a later stage holds a bubble, so in_ready
//   drops only once all 81 stages are full. Nothing is lost or repeated.
// ----------------------------------------------------------------------------
module ripemd160_32byte_hash
    import rmd160_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [63:0] message_word_0,
    input  logic [63:0] message_word_1,
    input  logic [63:0] message_word_2,
    input  logic [63:0] message_word_3,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] digest_word_0,
    output logic [63:0] digest_word_1,
    output logic [31:0] digest_word_2
);

    rmd_state_t stage_state [NUM_ROUNDS+1];
    logic       stage_valid [NUM_ROUNDS+1];
    logic       stage_ready [NUM_ROUNDS+1];

    // initial stage input: left line, right line, then message words
    assign stage_state[0] = {H0, H1, H2, H3, H4,
                             H0, H1, H2, H3, H4,
                             message_word_3, message_word_2,
                             message_word_1, message_word_0};

    assign stage_valid[0] = in_valid;
    assign in_ready       = stage_ready[0];

    // round stages
    for (genvar r = 0; r < NUM_ROUNDS; r++)
    begin : g_round
        rmd160_round #(
            .ROUND (r)
        ) u_round (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (stage_valid[r]),
            .in_ready  (stage_ready[r]),
            .in_state  (stage_state[r]),
            .out_valid (stage_valid[r+1]),
            .out_ready (stage_ready[r+1]),
            .out_state (stage_state[r+1])
        );
    end

    // cross-addition and output register
    rmd160_final u_final (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (stage_valid[NUM_ROUNDS]),
        .in_ready      (stage_ready[NUM_ROUNDS]),
        .in_state      (stage_state[NUM_ROUNDS]),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .digest_word_0 (digest_word_0),
        .digest_word_1 (digest_word_1),
        .digest_word_2 (digest_word_2)
    );

endmodule
